// ===== rtl/core/png_stored_deflate_encoder_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the PNG stored deflate encoder
// Shorthand for clocked assertions with the usual reset qualifier.
// ---------------------------------------------------------------------------
`ifndef PNG_STORED_DEFLATE_ENCODER_UNIT_ASSERT_SVH
`define PNG_STORED_DEFLATE_ENCODER_UNIT_ASSERT_SVH

// Implication in the same cycle.
`define PNGSE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pngse assertion failed");

// Implication in the next cycle.
`define PNGSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pngse assertion failed");

`endif

// ===== rtl/core/pngse_pkg.sv =====
// ---------------------------------------------------------------------------
// PNG stored deflate encoder package
// Shared types, constants and helper functions.
// ---------------------------------------------------------------------------
package pngse_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W = 13;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;
    localparam int Q_CW = 3;

    localparam logic REG_WIDTH = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       row_start;
        logic       last_px;
    } entry_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [31:0] crc_upd(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/pngse_queue.sv =====
// ---------------------------------------------------------------------------
// Entry queue
// Short first-in first-out queue between the classifier and the sequencer.
// ---------------------------------------------------------------------------
module pngse_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pngse_pkg::entry_t push_data,
    input  logic             pop,
    output pngse_pkg::entry_t head,
    output logic             head_valid,
    output logic             full
);
    import pngse_pkg::*;

    entry_t           mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_CW-1:0]  count_reg;
    logic [Q_CW-1:0]  count_next;

    assign head = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full = (count_reg == Q_CW'(Q_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/pngse_front.sv =====
// ---------------------------------------------------------------------------
// Input classifier
// Accepts pixel bytes and marks file start, row start and the final byte.
// ---------------------------------------------------------------------------
module pngse_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                pixel_byte,
    input  logic [pngse_pkg::DIM_W-1:0] cfg_w,
    input  logic [pngse_pkg::DIM_W-1:0] cfg_h,
    input  logic                      q_full,
    output logic                      push,
    output pngse_pkg::entry_t         push_entry
);
    import pngse_pkg::*;

    logic             active_reg;
    logic [13:0]      col_reg;
    logic [DIM_W-1:0] row_reg;
    logic [13:0]      rowlen_reg;
    logic [DIM_W-1:0] nrows_reg;

    logic [13:0]      rowlen;
    logic [13:0]      col;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] nrows;
    logic             eor;
    logic             eof;

    assign in_stall = q_full;
    assign push = in_valid && !q_full;

    always_comb
    begin
        rowlen = active_reg ? rowlen_reg : ({1'b0, cfg_w} + {cfg_w, 1'b0});
        nrows = active_reg ? nrows_reg : cfg_h;
        col = active_reg ? col_reg : '0;
        rows = active_reg ? row_reg : '0;
        eor = ((col + 14'd1) == rowlen);
        eof = eor && ((rows + DIM_W'(1)) == nrows);
        push_entry.data = pixel_byte;
        push_entry.start = !active_reg;
        push_entry.row_start = (col == '0);
        push_entry.last_px = eof;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
            rowlen_reg <= 14'd3;
            nrows_reg <= DIM_W'(1);
        end
        else if (push)
        begin
            active_reg <= !eof;
            rowlen_reg <= rowlen;
            nrows_reg <= nrows;
            col_reg <= eor ? '0 : col + 14'd1;
            row_reg <= eor ? rows + DIM_W'(1) : rows;
        end
    end

endmodule

// ===== rtl/core/pngse_back.sv =====
// ---------------------------------------------------------------------------
// Stream sequencer
// Emits headers, block headers, raw bytes and trailers one byte per cycle while out_stall is low.
// ---------------------------------------------------------------------------
module pngse_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pngse_pkg::entry_t         head,
    input  logic                      head_valid,
    output logic                      pop,
    input  logic [pngse_pkg::DIM_W-1:0] cfg_w,
    input  logic [pngse_pkg::DIM_W-1:0] cfg_h,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_byte,
    output logic                      last_byte
);
    import pngse_pkg::*;

    localparam logic [1:0] PH_RAW = 2'd0;
    localparam logic [1:0] PH_HDR = 2'd1;
    localparam logic [1:0] PH_BLK = 2'd2;
    localparam logic [1:0] PH_TRL = 2'd3;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    logic [1:0]       phase_reg, phase_next;
    logic [5:0]       idx_reg, idx_next;
    logic             active_reg, active_next;
    logic             filt_reg, filt_next;
    logic [DIM_W-1:0] run_w_reg, run_w_next;
    logic [DIM_W-1:0] run_h_reg, run_h_next;
    logic [25:0]      raw_len_reg;
    logic [10:0]      nb_reg;
    logic [26:0]      idat_reg;
    logic [25:0]      raw_rem_reg, raw_rem_next;
    logic [15:0]      blk_rem_reg, blk_rem_next;
    logic [15:0]      blk_len_reg, blk_len_next;
    logic [31:0]      crc_reg;
    logic [15:0]      lo_reg, lo_next;
    logic [15:0]      hi_reg, hi_next;
    logic             ov_reg;
    logic [7:0]       ob_reg;
    logic             ol_reg;

    logic             adv;
    logic             emit;
    logic [7:0]       eb;
    logic             ecrc;
    logic             crst;
    logic             elast;
    logic             need_filt;
    logic [7:0]       rb;
    logic [15:0]      blk_n;
    logic [16:0]      lo_sum, hi_sum;
    logic [16:0]      lo_mod, hi_mod;
    logic [13:0]      w3p1;
    logic [16:0]      r_fold;
    logic             r_ge;
    logic [16:0]      r_rem;
    logic [31:0]      crc_base;

    assign adv = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign out_byte = ob_reg;
    assign last_byte = ol_reg;

    assign w3p1 = {1'b0, run_w_reg} + {run_w_reg, 1'b0} + 14'd1;
    assign r_fold = {1'b0, raw_len_reg[15:0]} + {7'd0, raw_len_reg[25:16]};
    assign r_ge = (r_fold >= 17'd65535);
    assign r_rem = r_ge ? r_fold - 17'd65535 : r_fold;

    always_comb
    begin
        need_filt = head.row_start && !filt_reg;
        rb = need_filt ? 8'd0 : head.data;
        blk_n = (raw_rem_reg > 26'd65535) ? 16'hFFFF : raw_rem_reg[15:0];
        lo_sum = {1'b0, lo_reg} + {9'd0, rb};
        lo_mod = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
        hi_sum = {1'b0, hi_reg} + lo_mod;
        hi_mod = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
    end

    always_comb
    begin
        phase_next = phase_reg;
        idx_next = idx_reg;
        active_next = active_reg;
        filt_next = filt_reg;
        run_w_next = run_w_reg;
        run_h_next = run_h_reg;
        raw_rem_next = raw_rem_reg;
        blk_rem_next = blk_rem_reg;
        blk_len_next = blk_len_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        emit = 1'b0;
        eb = 8'd0;
        ecrc = 1'b0;
        crst = 1'b0;
        elast = 1'b0;
        pop = 1'b0;
        unique case (phase_reg)
            PH_RAW:
            begin
                if (head_valid)
                begin
                    emit = 1'b1;
                    if (head.start && !active_reg)
                    begin
                        eb = 8'h89;
                        phase_next = PH_HDR;
                        idx_next = 6'd1;
                        run_w_next = cfg_w;
                        run_h_next = cfg_h;
                    end
                    else if (blk_rem_reg == '0)
                    begin
                        eb = ({10'd0, blk_n} == raw_rem_reg) ? 8'd1 : 8'd0;
                        ecrc = 1'b1;
                        blk_len_next = blk_n;
                        blk_rem_next = blk_n;
                        phase_next = PH_BLK;
                        idx_next = 6'd1;
                    end
                    else
                    begin
                        eb = rb;
                        ecrc = 1'b1;
                        blk_rem_next = blk_rem_reg - 16'd1;
                        raw_rem_next = raw_rem_reg - 26'd1;
                        lo_next = lo_mod[15:0];
                        hi_next = hi_mod[15:0];
                        if (need_filt)
                        begin
                            filt_next = 1'b1;
                        end
                        else
                        begin
                            pop = adv;
                            filt_next = 1'b0;
                            if (head.last_px)
                            begin
                                phase_next = PH_TRL;
                                idx_next = 6'd0;
                            end
                        end
                    end
                end
            end
            PH_HDR:
            begin
                emit = 1'b1;
                idx_next = idx_reg + 6'd1;
                unique case (idx_reg)
                    6'd1: eb = 8'h50;
                    6'd2: eb = 8'h4E;
                    6'd3: eb = 8'h47;
                    6'd4: eb = 8'h0D;
                    6'd5: eb = 8'h0A;
                    6'd6: eb = 8'h1A;
                    6'd7: eb = 8'h0A;
                    6'd11: eb = 8'h0D;
                    6'd12: eb = 8'h49;
                    6'd13: eb = 8'h48;
                    6'd14: eb = 8'h44;
                    6'd15: eb = 8'h52;
                    6'd18: eb = {3'd0, run_w_reg[12:8]};
                    6'd19: eb = run_w_reg[7:0];
                    6'd22: eb = {3'd0, run_h_reg[12:8]};
                    6'd23: eb = run_h_reg[7:0];
                    6'd24: eb = 8'h08;
                    6'd25: eb = 8'h02;
                    6'd29: eb = ~crc_reg[31:24];
                    6'd30: eb = ~crc_reg[23:16];
                    6'd31: eb = ~crc_reg[15:8];
                    6'd32: eb = ~crc_reg[7:0];
                    6'd33: eb = {5'd0, idat_reg[26:24]};
                    6'd34: eb = idat_reg[23:16];
                    6'd35: eb = idat_reg[15:8];
                    6'd36: eb = idat_reg[7:0];
                    6'd37: eb = 8'h49;
                    6'd38: eb = 8'h44;
                    6'd39: eb = 8'h41;
                    6'd40: eb = 8'h54;
                    6'd41: eb = 8'h78;
                    6'd42: eb = 8'h01;
                    default: eb = 8'h00;
                endcase
                ecrc = ((idx_reg >= 6'd12) && (idx_reg <= 6'd28)) || (idx_reg >= 6'd37);
                crst = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                if (idx_reg == 6'd37)
                begin
                    lo_next = 16'd1;
                    hi_next = 16'd0;
                    blk_rem_next = '0;
                    filt_next = 1'b0;
                end
                if (idx_reg == 6'd42)
                begin
                    phase_next = PH_RAW;
                    active_next = 1'b1;
                    raw_rem_next = raw_len_reg;
                end
            end
            PH_BLK:
            begin
                emit = 1'b1;
                ecrc = 1'b1;
                idx_next = idx_reg + 6'd1;
                unique case (idx_reg[2:0])
                    3'd1: eb = blk_len_reg[7:0];
                    3'd2: eb = blk_len_reg[15:8];
                    3'd3: eb = ~blk_len_reg[7:0];
                    default: eb = ~blk_len_reg[15:8];
                endcase
                if (idx_reg == 6'd4)
                begin
                    phase_next = PH_RAW;
                end
            end
            PH_TRL:
            begin
                emit = 1'b1;
                idx_next = idx_reg + 6'd1;
                unique case (idx_reg)
                    6'd0: eb = hi_reg[15:8];
                    6'd1: eb = hi_reg[7:0];
                    6'd2: eb = lo_reg[15:8];
                    6'd3: eb = lo_reg[7:0];
                    6'd4, 6'd16: eb = ~crc_reg[31:24];
                    6'd5, 6'd17: eb = ~crc_reg[23:16];
                    6'd6, 6'd18: eb = ~crc_reg[15:8];
                    6'd7, 6'd19: eb = ~crc_reg[7:0];
                    6'd12: eb = 8'h49;
                    6'd13: eb = 8'h45;
                    6'd14: eb = 8'h4E;
                    6'd15: eb = 8'h44;
                    default: eb = 8'h00;
                endcase
                ecrc = (idx_reg <= 6'd3) || ((idx_reg >= 6'd12) && (idx_reg <= 6'd15));
                crst = (idx_reg == 6'd12);
                if (idx_reg == 6'd19)
                begin
                    elast = 1'b1;
                    phase_next = PH_RAW;
                    active_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_RAW;
            end
        endcase
    end

    assign crc_base = crst ? 32'hFFFFFFFF : crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RAW;
            idx_reg <= '0;
            active_reg <= 1'b0;
            filt_reg <= 1'b0;
            raw_rem_reg <= '0;
            blk_rem_reg <= '0;
            crc_reg <= 32'hFFFFFFFF;
            lo_reg <= 16'd1;
            hi_reg <= 16'd0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= emit;
            if (emit)
            begin
                phase_reg <= phase_next;
                idx_reg <= idx_next;
                active_reg <= active_next;
                filt_reg <= filt_next;
                raw_rem_reg <= raw_rem_next;
                blk_rem_reg <= blk_rem_next;
                lo_reg <= lo_next;
                hi_reg <= hi_next;
                if (ecrc)
                begin
                    crc_reg <= crc_upd(crc_base, eb);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            ob_reg <= eb;
            ol_reg <= elast;
            run_w_reg <= run_w_next;
            run_h_reg <= run_h_next;
            blk_len_reg <= blk_len_next;
        end
        raw_len_reg <= 26'(w3p1 * run_h_reg);
        nb_reg <= {1'b0, raw_len_reg[25:16]} + {10'd0, r_ge} + {10'd0, (r_rem != '0)};
        idat_reg <= 27'd6 + {1'b0, raw_len_reg} + {14'd0, nb_reg, 2'b00} + {16'd0, nb_reg};
    end

endmodule

// ===== rtl/core/png_stored_deflate_encoder_unit.sv =====
// An accepted pixel byte passes through the entry queue and then the sequencer output register.
// Throughput: one byte per cycle in and out while out_stall is low; the output byte stream sets the pace.
// Each file adds 43 bytes of signature, IHDR, IDAT head and zlib header before its first
// pixel byte, each stored block a 5-byte header, each row a filter byte, and the end 20.
// Reset: both dimension registers read 1 and the encoder waits for the first byte of a file.
// ---------------------------------------------------------------------------
// PNG stored deflate encoder
// Turns a stream of RGB bytes into the bytes of a PNG file with stored deflate.
// ---------------------------------------------------------------------------
module png_stored_deflate_encoder_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [pngse_pkg::DIM_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                pixel_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_byte,
    output logic                      last_byte
);
    import pngse_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             q_full;
    logic             push;
    entry_t           push_entry;
    entry_t           head;
    logic             head_valid;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH: width_reg <= clamp_dim(cfg_data);
                REG_HEIGHT: height_reg <= clamp_dim(cfg_data);
                default: width_reg <= width_reg;
            endcase
        end
    end

    pngse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_byte (pixel_byte),
        .cfg_w      (width_reg),
        .cfg_h      (height_reg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    pngse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    pngse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .cfg_w      (width_reg),
        .cfg_h      (height_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

endmodule

// ===== rtl/core/pngse_checker.sv =====
// ---------------------------------------------------------------------------
// Port checker for the PNG stored deflate encoder
// Watches the output channel for handshake and file framing errors.
// ---------------------------------------------------------------------------
`include "png_stored_deflate_encoder_unit_assert.svh"

module pngse_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [7:0]                out_byte,
    input logic                      last_byte
);

    // A stalled word stays valid and unchanged.
    `PNGSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `PNGSE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_byte) && $stable(last_byte))
    // The file always ends with the fixed IEND checksum.
    `PNGSE_ASSERT_SAME(a_last_crc, out_valid && last_byte, out_byte == 8'h82)
    // A byte that follows the last byte of a file at once is the signature byte of the next file.
    `PNGSE_ASSERT_NEXT(a_next_sig, out_valid && !out_stall && last_byte, !out_valid || out_byte == 8'h89)

endmodule

bind png_stored_deflate_encoder_unit pngse_checker u_chk (.*);
